[rtl/core/hpd_pkg.sv]
// ----------------------------------------------------------------------------
// hpd_pkg
// Shared types and constants of the MP3 Huffman pair decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package hpd_pkg;

  // input word commands
  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_BYTE  = 2'd2;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 9;
  localparam logic [CFG_IDX_W-1:0] CFG_ESCAPE_BITS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PAIR_TOTAL     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES_IN_USE = 2'd2;

  localparam int unsigned CODE_W  = 24;
  localparam int unsigned LEN_W   = 5;
  localparam int unsigned VAL_W   = 16;
  localparam int unsigned COEF_W  = 15;
  localparam int unsigned WIN_W   = 64;
  localparam int unsigned HELD_W  = 7;
  localparam int unsigned WIN_LIMIT = 63;
  localparam int unsigned ESC_MAG = 15;
  localparam int unsigned PAIRS_PER_WORD = 8;
  localparam int unsigned PAIR_CNT_W = 4;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  slot;
    logic [23:0] code_bits;
    logic [4:0]  code_len;
    logic [15:0] pair_value;
    logic [7:0]  stream_byte;
    logic [2:0]  skip_bits;
  } in_word_t;

  typedef struct packed {
    logic signed [14:0] coefficient;
    logic               last;
    logic               decode_error;
  } out_word_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
    logic [VAL_W-1:0]  value;
  } entry_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic scan_start;
    logic apply_plain;
    logic apply_escape;
    logic rd_lin_x;
    logic rd_sgn_x;
    logic rd_lin_y;
    logic rd_sgn_y;
    logic emit_x;
    logic emit_y;
    logic emit_err;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic go;
    logic halted;
    logic pend;
    logic cap;
    logic scan_done;
    logic found;
    logic escape;
    logic enough;
    logic too_long;
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

[rtl/core/mp3_huffman_pair_decoder.sv]
// ----------------------------------------------------------------------------
// mp3_huffman_pair_decoder
// Huffman pair decoder with linbits escape, fed one stream byte per word.
// ----------------------------------------------------------------------------
//   channel  dir  handshake           payload
//   in       in   in_valid/in_ready   hpd_pkg::in_word_t (load, start, byte)
//   out      out  out_valid/out_ready hpd_pkg::out_word_t (one coefficient)
//   cfg      in   cfg_we              cfg_index, cfg_data (no read-back)
//
// A stream byte is followed by a table scan per pair, one entry per cycle,
// and by the escape reads of an escape pair; up to 8 pairs per byte.
// The table RAM read port sets the pair time. Reset clears control state;
// the table is undefined until loaded. A stalled output holds the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module mp3_huffman_pair_decoder #(
  parameter int unsigned TABLE_DEPTH     = 256,
  parameter int unsigned MAX_CODE_LEN    = 24,
  parameter int unsigned MAX_ESCAPE_BITS = 13
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire hpd_pkg::in_word_t              in_data_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output hpd_pkg::out_word_t                  out_data_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [hpd_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [hpd_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  hpd_pkg::dp_cmd_t  cmd;
  hpd_pkg::dp_stat_t stat;

  // sequencer: one pair at a time
  hpd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // table, bit window and output register
  hpd_datapath #(
    .TABLE_DEPTH     (TABLE_DEPTH),
    .MAX_CODE_LEN    (MAX_CODE_LEN),
    .MAX_ESCAPE_BITS (MAX_ESCAPE_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

[rtl/core/hpd_datapath.sv]
// ----------------------------------------------------------------------------
// hpd_datapath
// Code table, bit window, table scan, escape reads and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module hpd_datapath #(
  parameter int unsigned TABLE_DEPTH     = 256,
  parameter int unsigned MAX_CODE_LEN    = 24,
  parameter int unsigned MAX_ESCAPE_BITS = 13
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire hpd_pkg::in_word_t                in_data_i,
  input  wire logic                             cfg_we_i,
  input  wire logic [hpd_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [hpd_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  wire hpd_pkg::dp_cmd_t                 cmd_i,
  output hpd_pkg::dp_stat_t                     stat_o,
  input  wire logic                             out_ready_i,
  output logic                                  out_valid_o,
  output hpd_pkg::out_word_t                    out_data_o
);

  localparam int unsigned AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned MEB   = MAX_ESCAPE_BITS;
  localparam int unsigned MCL   = MAX_CODE_LEN;
  localparam int unsigned MAG_W = hpd_pkg::COEF_W - 1;
  localparam int unsigned WW    = hpd_pkg::WIN_W;
  localparam int unsigned HW    = hpd_pkg::HELD_W;

  // slot modulo table depth: quotient below 16, four restoring steps
  function automatic logic [AW-1:0] slot_index(input logic [7:0] s);
    int v;
    v = int'(s);
    for (int k = 3; k >= 0; k--) begin
      if (v >= (int'(TABLE_DEPTH) << k)) v = v - (int'(TABLE_DEPTH) << k);
    end
    return AW'(v);
  endfunction

  // config
  logic [3:0] esc_bits_q;
  logic [8:0] pair_total_q, entries_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_bits_q   <= '0;
      pair_total_q <= '0;
      entries_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        hpd_pkg::CFG_ESCAPE_BITS:    esc_bits_q   <= cfg_data_i[3:0];
        hpd_pkg::CFG_PAIR_TOTAL:     pair_total_q <= cfg_data_i;
        hpd_pkg::CFG_ENTRIES_IN_USE: entries_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [3:0]       lin;
  logic [CNT_W-1:0] used;
  always_comb begin
    lin  = (esc_bits_q > 4'(MEB)) ? 4'(MEB) : esc_bits_q;
    used = (32'(entries_q) > TABLE_DEPTH) ? CNT_W'(TABLE_DEPTH) : CNT_W'(entries_q);
  end

  // code table
  hpd_pkg::entry_t entry_mem [TABLE_DEPTH];
  hpd_pkg::entry_t rd_q;
  logic [CNT_W-1:0] issue_q;
  logic             load;

  assign load = cmd_i.accept && (in_data_i.cmd == hpd_pkg::CMD_LOAD);

  always_ff @(posedge clk_i) begin
    if (load) begin
      entry_mem[slot_index(in_data_i.slot)] <=
        '{code: in_data_i.code_bits, len: in_data_i.code_len, value: in_data_i.pair_value};
    end
    rd_q <= entry_mem[issue_q[AW-1:0]];
  end

  // state
  logic [WW-1:0]   win_q, win_d;
  logic [HW-1:0]   held_q, held_d;
  logic [2:0]      skip_q, skip_d;
  logic [8:0]      done_q, done_d;
  logic            halted_q, halted_d, pend_q, pend_d;
  logic signed [7:0] px_q, px_d, py_q, py_d;
  logic [MAG_W-1:0]  magx_q, magx_d, magy_q, magy_d;
  logic signed [hpd_pkg::COEF_W-1:0] cx_q, cx_d, cy_q, cy_d;
  logic [hpd_pkg::PAIR_CNT_W-1:0] items_q, items_d;

  // scan
  logic [CNT_W-1:0] issue_d;
  logic             scan_on_q, scan_on_d, rd_vld_q, rd_vld_d;
  logic [MCL-1:0]   head_q, head_d;
  logic [5:0]       maxl_q, maxl_d;
  logic             found_q, found_d;
  logic [hpd_pkg::LEN_W-1:0] best_len_q, best_len_d;
  logic [hpd_pkg::VAL_W-1:0] best_val_q, best_val_d;

  // output
  logic                 out_vld_q, out_vld_d;
  hpd_pkg::out_word_t   out_q, out_d;

  // decoded match
  logic signed [7:0] mx, my;
  logic [7:0]  ax, ay, apx, apy;
  logic        esc;
  logic [hpd_pkg::LEN_W-1:0] esc_take;
  logic [5:0]  need_x, need_y;
  logic        hit, scan_done;

  // shared take unit
  logic            take_en;
  logic [5:0]      take_n;
  logic [WW-1:0]   shifted;
  logic [MEB:0]    one_sh;
  logic [MEB-1:0]  peek_val;
  logic [HW-1:0]   held_tk;

  // append
  logic [3:0]      nb;
  logic [7:0]      byte_m;
  logic [WW+MCL-1:0] ext;
  logic            fin;

  always_comb begin
    mx = $signed(best_val_q[15:8]);
    my = $signed(best_val_q[7:0] ^ 8'h80);
    ax = mx[7] ? 8'(-mx) : 8'(mx);
    ay = my[7] ? 8'(-my) : 8'(my);
    esc = (ax == 8'(hpd_pkg::ESC_MAG)) || (ay == 8'(hpd_pkg::ESC_MAG));
    if (best_len_q > ((9'(ax) + 9'(ay) > 9'(hpd_pkg::ESC_MAG)) ? 5'd2 : 5'd1)) begin
      esc_take = best_len_q - ((9'(ax) + 9'(ay) > 9'(hpd_pkg::ESC_MAG)) ? 5'd2 : 5'd1);
    end else begin
      esc_take = '0;
    end
    apx = px_q[7] ? 8'(-px_q) : 8'(px_q);
    apy = py_q[7] ? 8'(-py_q) : 8'(py_q);
    need_x = (apx == 8'(hpd_pkg::ESC_MAG)) ? 6'(lin) + 6'd1 : 6'(apx != 8'd0);
    need_y = (apy == 8'(hpd_pkg::ESC_MAG)) ? 6'(lin) + 6'd1 : 6'(apy != 8'd0);

    hit = rd_vld_q && (rd_q.len != '0) && (6'(rd_q.len) <= maxl_q) &&
          (32'(rd_q.code) == 32'(head_q >> (6'(MCL) - 6'(rd_q.len))));
    scan_done = scan_on_q && (issue_q == used) && !rd_vld_q;
    fin = (10'(done_q) + 10'd1) >= 10'(pair_total_q);
  end

  always_comb begin
    take_en = 1'b0;
    take_n  = '0;
    if (cmd_i.apply_plain) begin
      take_en = 1'b1; take_n = 6'(best_len_q);
    end else if (cmd_i.apply_escape) begin
      take_en = 1'b1; take_n = 6'(esc_take);
    end else if (cmd_i.rd_lin_x && apx == 8'(hpd_pkg::ESC_MAG)) begin
      take_en = 1'b1; take_n = 6'(lin);
    end else if (cmd_i.rd_lin_y && apy == 8'(hpd_pkg::ESC_MAG)) begin
      take_en = 1'b1; take_n = 6'(lin);
    end else if (cmd_i.rd_sgn_x && magx_q != '0) begin
      take_en = 1'b1; take_n = 6'd1;
    end else if (cmd_i.rd_sgn_y && magy_q != '0) begin
      take_en = 1'b1; take_n = 6'd1;
    end
    shifted  = win_q >> (held_q - HW'(take_n));
    one_sh   = (MEB+1)'(1) << take_n;
    peek_val = shifted[MEB-1:0] & MEB'(one_sh - (MEB+1)'(1));
    held_tk  = held_q - HW'(take_n);
  end

  always_comb begin
    win_d = win_q; held_d = held_q; skip_d = skip_q; done_d = done_q;
    halted_d = halted_q; pend_d = pend_q; px_d = px_q; py_d = py_q;
    magx_d = magx_q; magy_d = magy_q; cx_d = cx_q; cy_d = cy_q; items_d = items_q;
    issue_d = issue_q; scan_on_d = scan_on_q; rd_vld_d = 1'b0;
    head_d = head_q; maxl_d = maxl_q; found_d = found_q;
    best_len_d = best_len_q; best_val_d = best_val_q;
    out_vld_d = out_vld_q && !out_ready_i; out_d = out_q;
    nb     = 4'd8 - 4'(skip_q);
    byte_m = in_data_i.stream_byte & (8'hFF >> skip_q);
    ext    = {win_q, MCL'(0)} >> held_q;

    if (cmd_i.accept && in_data_i.cmd == hpd_pkg::CMD_START) begin
      win_d = '0; held_d = '0; done_d = '0; pend_d = 1'b0;
      px_d = '0; py_d = '0;
      skip_d = in_data_i.skip_bits;
      halted_d = (pair_total_q == '0);
    end
    if (cmd_i.accept && in_data_i.cmd == hpd_pkg::CMD_BYTE && !halted_q) begin
      if (8'(held_q) + 8'(nb) <= 8'(hpd_pkg::WIN_LIMIT)) begin
        win_d  = (win_q << nb) | WW'(byte_m);
        held_d = held_q + HW'(nb);
      end
      skip_d  = '0;
      items_d = '0;
    end

    // table scan, one entry per cycle
    if (cmd_i.scan_start) begin
      scan_on_d = 1'b1; issue_d = '0; found_d = 1'b0;
      head_d = ext[MCL-1:0];
      maxl_d = (32'(held_q) < MCL) ? 6'(held_q) : 6'(MCL);
    end else if (scan_on_q) begin
      if (issue_q != used) begin
        rd_vld_d = 1'b1;
        issue_d  = issue_q + CNT_W'(1);
      end
      if (hit && (!found_q || rd_q.len < best_len_q)) begin
        found_d = 1'b1; best_len_d = rd_q.len; best_val_d = rd_q.value;
      end
      if (scan_done) scan_on_d = 1'b0;
    end

    if (take_en) begin
      held_d = held_tk;
      win_d  = win_q & ~({WW{1'b1}} << held_tk);
    end

    if (cmd_i.apply_plain) begin
      cx_d = hpd_pkg::COEF_W'(mx);
      cy_d = hpd_pkg::COEF_W'(my);
    end
    if (cmd_i.apply_escape) begin
      pend_d = 1'b1; px_d = mx; py_d = my;
    end
    if (cmd_i.rd_lin_x) begin
      magx_d = (apx == 8'(hpd_pkg::ESC_MAG)) ? MAG_W'(peek_val) + MAG_W'(hpd_pkg::ESC_MAG)
                                             : MAG_W'(apx);
    end
    if (cmd_i.rd_lin_y) begin
      magy_d = (apy == 8'(hpd_pkg::ESC_MAG)) ? MAG_W'(peek_val) + MAG_W'(hpd_pkg::ESC_MAG)
                                             : MAG_W'(apy);
    end
    if (cmd_i.rd_sgn_x) begin
      cx_d = peek_val[0] ? -$signed({1'b0, magx_q}) : $signed({1'b0, magx_q});
    end
    if (cmd_i.rd_sgn_y) begin
      cy_d = peek_val[0] ? -$signed({1'b0, magy_q}) : $signed({1'b0, magy_q});
    end

    if (cmd_i.emit_x) begin
      out_vld_d = 1'b1;
      out_d = '{coefficient: cx_q, last: 1'b0, decode_error: 1'b0};
    end
    if (cmd_i.emit_y) begin
      out_vld_d = 1'b1;
      out_d = '{coefficient: cy_q, last: fin, decode_error: 1'b0};
      done_d  = done_q + 9'd1;
      items_d = items_q + hpd_pkg::PAIR_CNT_W'(1);
      pend_d  = 1'b0;
      if (fin) halted_d = 1'b1;
    end
    if (cmd_i.emit_err) begin
      out_vld_d = 1'b1;
      out_d = '{coefficient: '0, last: 1'b1, decode_error: 1'b1};
      halted_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0; held_q <= '0; skip_q <= '0; done_q <= '0;
      halted_q <= 1'b1; pend_q <= 1'b0; px_q <= '0; py_q <= '0;
      items_q <= '0; issue_q <= '0; scan_on_q <= 1'b0; rd_vld_q <= 1'b0;
      found_q <= 1'b0; out_vld_q <= 1'b0;
    end else begin
      win_q <= win_d; held_q <= held_d; skip_q <= skip_d; done_q <= done_d;
      halted_q <= halted_d; pend_q <= pend_d; px_q <= px_d; py_q <= py_d;
      items_q <= items_d; issue_q <= issue_d; scan_on_q <= scan_on_d;
      rd_vld_q <= rd_vld_d; found_q <= found_d; out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    magx_q <= magx_d; magy_q <= magy_d; cx_q <= cx_d; cy_q <= cy_d;
    head_q <= head_d; maxl_q <= maxl_d;
    best_len_q <= best_len_d; best_val_q <= best_val_d;
    out_q <= out_d;
  end

  always_comb begin
    stat_o.go        = (in_data_i.cmd == hpd_pkg::CMD_BYTE) && !halted_q;
    stat_o.halted    = halted_q;
    stat_o.pend      = pend_q;
    stat_o.cap       = (32'(items_q) == hpd_pkg::PAIRS_PER_WORD);
    stat_o.scan_done = scan_done;
    stat_o.found     = found_q;
    stat_o.escape    = esc;
    stat_o.enough    = 7'(held_q) >= 7'(need_x + need_y);
    stat_o.too_long  = (32'(held_q) >= MCL);
    stat_o.out_free  = !out_vld_q || out_ready_i;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

[rtl/core/hpd_ctrl.sv]
// ----------------------------------------------------------------------------
// hpd_ctrl
// Sequencer: scan, match, escape reads and result emission per pair.
// ----------------------------------------------------------------------------
`default_nettype none

module hpd_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire hpd_pkg::dp_stat_t stat_i,
  output hpd_pkg::dp_cmd_t       cmd_o
);

  typedef enum logic [10:0] {
    S_IDLE     = 11'b000_0000_0001,
    S_DECIDE   = 11'b000_0000_0010,
    S_SCAN     = 11'b000_0000_0100,
    S_MATCH    = 11'b000_0000_1000,
    S_RDX_LIN  = 11'b000_0001_0000,
    S_RDX_SGN  = 11'b000_0010_0000,
    S_RDY_LIN  = 11'b000_0100_0000,
    S_RDY_SGN  = 11'b000_1000_0000,
    S_EMIT_X   = 11'b001_0000_0000,
    S_EMIT_Y   = 11'b010_0000_0000,
    S_EMIT_ERR = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = (state_q == S_IDLE);
    unique case (state_q)
      S_IDLE: begin
        cmd_o.accept = in_valid_i;
        if (in_valid_i && stat_i.go) state_d = S_DECIDE;
      end
      S_DECIDE: begin
        if (stat_i.halted || stat_i.cap) state_d = S_IDLE;
        else if (!stat_i.pend) begin
          cmd_o.scan_start = 1'b1;
          state_d = S_SCAN;
        end else if (stat_i.enough) state_d = S_RDX_LIN;
        else state_d = S_IDLE;
      end
      S_SCAN: begin
        if (stat_i.scan_done) state_d = S_MATCH;
      end
      S_MATCH: begin
        if (stat_i.found && stat_i.escape) begin
          cmd_o.apply_escape = 1'b1;
          state_d = S_DECIDE;
        end else if (stat_i.found) begin
          cmd_o.apply_plain = 1'b1;
          state_d = S_EMIT_X;
        end else if (stat_i.too_long) state_d = S_EMIT_ERR;
        else state_d = S_IDLE;
      end
      S_RDX_LIN: begin cmd_o.rd_lin_x = 1'b1; state_d = S_RDX_SGN; end
      S_RDX_SGN: begin cmd_o.rd_sgn_x = 1'b1; state_d = S_RDY_LIN; end
      S_RDY_LIN: begin cmd_o.rd_lin_y = 1'b1; state_d = S_RDY_SGN; end
      S_RDY_SGN: begin cmd_o.rd_sgn_y = 1'b1; state_d = S_EMIT_X; end
      S_EMIT_X: begin
        if (stat_i.out_free) begin
          cmd_o.emit_x = 1'b1;
          state_d = S_EMIT_Y;
        end
      end
      S_EMIT_Y: begin
        if (stat_i.out_free) begin
          cmd_o.emit_y = 1'b1;
          state_d = S_DECIDE;
        end
      end
      S_EMIT_ERR: begin
        if (stat_i.out_free) begin
          cmd_o.emit_err = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

endmodule

`default_nettype wire

[rtl/core/hpd_checker.sv]
// ----------------------------------------------------------------------------
// hpd_checker
// Port-level checks on the result channel of the pair decoder.
// ----------------------------------------------------------------------------
`default_nettype none

module hpd_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire hpd_pkg::out_word_t out_data_o
);

  // stalled word holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result word changed under stall");

  // error word is a terminal zero word
  a_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.decode_error |->
      out_data_o.last && out_data_o.coefficient == 15'sd0)
    else $error("error word malformed");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.coefficient >= -15'sd8206 &&
                    out_data_o.coefficient <= 15'sd8206)
    else $error("coefficient out of range");

endmodule

bind mp3_huffman_pair_decoder hpd_checker u_hpd_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire

[dv/mp3_huffman_pair_decoder_tb.sv]
// ----------------------------------------------------------------------------
// mp3_huffman_pair_decoder_tb
// Self-checking bench: loads a code table, runs a short table of directed
// words (empty block, no-match error, escapes, clamped registers), then random
// blocks over several register settings. Every output word is compared with
// an in-bench predictor of the decoder or with a typed expected word.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module mp3_huffman_pair_decoder_tb;

  localparam int unsigned TBL_N       = 256;
  localparam int unsigned LOADED_N    = 20;       // slots written before any scan
  localparam int unsigned CODE_MAX    = 24;
  localparam int unsigned LIN_MAX     = 13;
  localparam int unsigned WORDS_CAP   = 16;
  localparam int unsigned SETTLE_CYC  = 3000;     // worst scan of 8 pairs, with margin
  localparam int unsigned CYCLE_LIMIT = 3000000;
  localparam int unsigned PHASE_BYTES = 5;
  localparam logic [1:0]  CMD_NOP     = 2'd3;     // unused command, ignored by the block

  typedef enum logic {ROW_CFG, ROW_WORD} row_kind_e;

  typedef struct {
    row_kind_e                      kind;
    logic [hpd_pkg::CFG_IDX_W-1:0]  idx;
    logic [hpd_pkg::CFG_DATA_W-1:0] data;
    hpd_pkg::in_word_t              w;
    int                             n_typed;   // -1: use predictor
    hpd_pkg::out_word_t             t0;
    hpd_pkg::out_word_t             t1;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  hpd_pkg::in_word_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  hpd_pkg::out_word_t out_data;
  logic cfg_we = 1'b0;
  logic [hpd_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [hpd_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  mp3_huffman_pair_decoder dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Decoder predictor: shadow table, bit window and block state
  // --------------------------------------------------------------------------
  logic [23:0] tbl_code [TBL_N];
  logic [4:0]  tbl_len  [TBL_N];
  logic [15:0] tbl_val  [TBL_N];
  logic [63:0] win = '0;
  int unsigned held = 0, pairs = 0, skip_left = 0;
  bit          blk_halted = 1'b1, esc_pend = 1'b0;
  int          pend_x = 0, pend_y = 0;
  logic [3:0]  esc_cfg = '0;
  logic [8:0]  total_cfg = '0, used_cfg = '0;

  hpd_pkg::out_word_t step_q[$];     // words caused by the last accepted input word
  hpd_pkg::out_word_t coef_q[$];     // words still owed by the DUT
  int fails = 0;
  int words_seen = 0;

  function automatic logic [63:0] low_bits(int unsigned n);
    return n >= 64 ? '1 : ((64'd1 << n) - 64'd1);
  endfunction

  function automatic logic [63:0] peek_bits(int unsigned n);
    if (n == 0 || n > held) return '0;
    return (win >> (held - n)) & low_bits(n);
  endfunction

  function automatic logic [63:0] take_bits(int unsigned n);
    logic [63:0] v;
    v = peek_bits(n);
    if (n > held) n = held;
    held -= n;
    win &= low_bits(held);
    return v;
  endfunction

  function automatic void push_coef(int c, bit l, bit e);
    logic [31:0] cv;
    cv = c;
    step_q.push_back(hpd_pkg::out_word_t'{coefficient: cv[14:0], last: l, decode_error: e});
  endfunction

  function automatic void emit_pair(int a, int b);
    bit fin;
    push_coef(a, 1'b0, 1'b0);
    fin = (pairs + 1 >= total_cfg);
    push_coef(b, fin, 1'b0);
    pairs = (pairs + 1) & 9'h1FF;
    if (fin) blk_halted = 1'b1;
  endfunction

  function automatic int unsigned linbits();
    return esc_cfg > LIN_MAX ? LIN_MAX : esc_cfg;
  endfunction

  function automatic int unsigned bits_for(int v);
    if (v == 15 || v == -15) return linbits() + 1;
    return v != 0 ? 1 : 0;
  endfunction

  function automatic int read_value(int v);
    int mag;
    mag = v < 0 ? -v : v;
    if (mag == 15) mag = int'(take_bits(linbits())) + 15;
    if (mag == 0) return 0;
    return take_bits(1) ? -mag : mag;
  endfunction

  // one accepted input word -> step_q
  function automatic void decode_word(hpd_pkg::in_word_t w);
    int unsigned nb, used, maxl, hit, back, clen;
    bit found;
    int x, y, ax, ay, a, b;
    step_q.delete();
    case (w.cmd)
      hpd_pkg::CMD_LOAD: begin
        tbl_code[w.slot] = w.code_bits;
        tbl_len[w.slot]  = w.code_len;
        tbl_val[w.slot]  = w.pair_value;
      end
      hpd_pkg::CMD_START: begin
        win = '0; held = 0; pairs = 0; esc_pend = 1'b0; pend_x = 0; pend_y = 0;
        skip_left = w.skip_bits;
        blk_halted = (total_cfg == 0);
      end
      hpd_pkg::CMD_BYTE: begin
        if (!blk_halted) begin
          nb = 8 - skip_left;
          if (held + nb <= 63) begin
            win = (win << nb) | ({56'd0, w.stream_byte} & low_bits(nb));
            held += nb;
          end
          skip_left = 0;
          while (!blk_halted && step_q.size() + 2 <= WORDS_CAP) begin
            if (!esc_pend) begin
              used = used_cfg > TBL_N ? TBL_N : used_cfg;
              maxl = held < CODE_MAX ? held : CODE_MAX;
              found = 1'b0;
              hit = 0;
              for (int unsigned len = 1; len <= maxl && !found; len++) begin
                for (int unsigned i = 0; i < used; i++) begin
                  if (tbl_len[i] == len && {40'd0, tbl_code[i]} == peek_bits(len)) begin
                    found = 1'b1;
                    hit = i;
                    break;
                  end
                end
              end
              if (!found) begin
                if (held >= CODE_MAX) begin
                  push_coef(0, 1'b1, 1'b1);
                  blk_halted = 1'b1;
                end
                break;
              end
              x = int'($signed(tbl_val[hit][15:8]));
              y = int'(tbl_val[hit][7:0]) - 128;
              ax = x < 0 ? -x : x;
              ay = y < 0 ? -y : y;
              clen = tbl_len[hit];
              if (ax == 15 || ay == 15) begin
                // sign bits at the tail of the code are handed back
                back = (ax + ay > 15) ? 2 : 1;
                void'(take_bits(clen > back ? clen - back : 0));
                esc_pend = 1'b1; pend_x = x; pend_y = y;
              end else begin
                void'(take_bits(clen));
                emit_pair(x, y);
              end
            end else begin
              if (held < bits_for(pend_x) + bits_for(pend_y)) break;
              a = read_value(pend_x);
              b = read_value(pend_y);
              esc_pend = 1'b0;
              emit_pair(a, b);
            end
          end
        end
      end
      default: ;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Output checker and watchdog
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : check_out
    hpd_pkg::out_word_t e;
    if (rst_n && out_valid && out_ready) begin
      words_seen++;
      if (coef_q.size() == 0) begin
        $error("unexpected output word: coefficient %0d last %0b error %0b",
               out_data.coefficient, out_data.last, out_data.decode_error);
        fails++;
      end else begin
        e = coef_q.pop_front();
        if (out_data.coefficient !== e.coefficient) begin
          $error("coefficient: expected %0d, got %0d", e.coefficient, out_data.coefficient);
          fails++;
        end
        if (out_data.last !== e.last) begin
          $error("last: expected %0b, got %0b", e.last, out_data.last);
          fails++;
        end
        if (out_data.decode_error !== e.decode_error) begin
          $error("decode_error: expected %0b, got %0b", e.decode_error,
                 out_data.decode_error);
          fails++;
        end
      end
    end
  end

  int unsigned cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL mp3_huffman_pair_decoder");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: random back-pressure, calm stretches, one long hold-off
  // --------------------------------------------------------------------------
  initial begin : sink
    int rest, long_hold, calm;
    bit hold_done;
    rest = 0; long_hold = 0; calm = 0; hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (!hold_done && words_seen >= 40) begin
        hold_done = 1'b1;
        long_hold = 800;    // sender keeps going, block must back up
      end
      if (long_hold > 0) begin
        out_ready <= 1'b0;
        long_hold--;
      end else if (calm > 0) begin
        out_ready <= 1'b1;
        calm--;
      end else if (rest > 0) begin
        out_ready <= 1'b0;
        rest--;
      end else begin
        case ($urandom_range(0, 99)) inside
          [0:59]:  out_ready <= 1'b1;
          [60:94]: begin out_ready <= 1'b0; rest = $urandom_range(0, 2); end
          [95:97]: begin out_ready <= 1'b0; rest = $urandom_range(5, 30); end
          default: begin out_ready <= 1'b1; calm = $urandom_range(50, 200); end
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic hpd_pkg::in_word_t noise_word();
    logic [95:0] r;
    hpd_pkg::in_word_t w;
    r = {$urandom, $urandom, $urandom};
    w = r[$bits(hpd_pkg::in_word_t)-1:0];
    return w;
  endfunction

  // drive one word, wait for the handshake, then predict it into step_q
  task automatic send_word(hpd_pkg::in_word_t w);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= w;
    do @(posedge clk); while (!in_ready);
    decode_word(w);
  endtask

  task automatic send_checked(hpd_pkg::in_word_t w);
    send_word(w);
    foreach (step_q[k]) coef_q.push_back(step_q[k]);
  endtask

  // wait out every owed word plus any scan that yields nothing
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (coef_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_reg(logic [hpd_pkg::CFG_IDX_W-1:0] idx,
                           logic [hpd_pkg::CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      hpd_pkg::CFG_ESCAPE_BITS:    esc_cfg   = data[3:0];
      hpd_pkg::CFG_PAIR_TOTAL:     total_cfg = data;
      hpd_pkg::CFG_ENTRIES_IN_USE: used_cfg  = data;
      default: ;
    endcase
  endtask

  function automatic hpd_pkg::in_word_t load_word(int unsigned s, logic [23:0] code,
                                                  logic [4:0] len, logic [15:0] val);
    hpd_pkg::in_word_t w;
    w = noise_word();
    w.cmd = hpd_pkg::CMD_LOAD; w.slot = 8'(s); w.code_bits = code; w.code_len = len;
    w.pair_value = val;
    return w;
  endfunction

  function automatic hpd_pkg::in_word_t cmd_word(logic [1:0] c, logic [7:0] b,
                                                 logic [2:0] sk);
    hpd_pkg::in_word_t w;
    w = '0;
    w.cmd = c; w.stream_byte = b; w.skip_bits = sk;
    return w;
  endfunction

  // packed pair value biased toward zero and the escape magnitude
  function automatic int pick_mag();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 15;
      2: return -15;
      3: return $urandom_range(0, 6) - 3;
      4: return $urandom_range(0, 255) - 128;
      default: return $urandom_range(0, 1) ? 14 : -1;
    endcase
  endfunction

  function automatic logic [15:0] pick_value();
    logic [31:0] xv, yv;
    xv = pick_mag();
    yv = pick_mag() + 128;
    return {xv[7:0], yv[7:0]};
  endfunction

  // Fixed prefix code: slot, code, length. Slot 16 shadows slot 0 (lower slot
  // wins), slots 14/15 carry lengths that never match, 24 ones never match.
  logic [23:0] code_of [17] = '{24'h0, 24'h4, 24'h5, 24'hC, 24'hD, 24'h1C, 24'h1D,
                                24'h3C, 24'h3D, 24'h7C, 24'h7D, 24'hFC, 24'hFFFFFE,
                                24'hFD, 24'h0, 24'hFFFFFF, 24'h0};
  logic [4:0]  len_of  [17] = '{5'd1, 5'd3, 5'd3, 5'd4, 5'd4, 5'd5, 5'd5, 5'd6,
                                5'd6, 5'd7, 5'd7, 5'd8, 5'd24, 5'd8, 5'd0, 5'd25,
                                5'd1};
  // directed values: zero pair, x escape, x and y escape, +1/-1, extremes,
  // y escape, opposite extremes, small pair
  logic [15:0] val_init [17] = '{16'h0080, 16'h0F80, 16'h0F8F, 16'h017F, 16'h80FF,
                                 16'h008F, 16'h7F00, 16'h0283, 16'hF171, 16'h0E7F,
                                 16'hFF81, 16'h0385, 16'h0A7B, 16'h0C8C, 16'h0080,
                                 16'h0080, 16'h0581};

  row_t rows[$];

  function automatic void add_cfg(logic [hpd_pkg::CFG_IDX_W-1:0] idx,
                                  logic [hpd_pkg::CFG_DATA_W-1:0] d);
    row_t r;
    r = '{kind: ROW_CFG, idx: idx, data: d, w: '0, n_typed: -1, t0: '0, t1: '0};
    rows.push_back(r);
  endfunction

  function automatic void add_word(hpd_pkg::in_word_t w, int n,
                                   hpd_pkg::out_word_t t0 = '0,
                                   hpd_pkg::out_word_t t1 = '0);
    row_t r;
    r = '{kind: ROW_WORD, idx: '0, data: '0, w: w, n_typed: n, t0: t0, t1: t1};
    rows.push_back(r);
  endfunction

  initial begin : stimulus
    hpd_pkg::out_word_t zero_w, zero_last, err_w;
    int unsigned phase_bytes, budget;
    logic [3:0] esc_pick [6];
    logic [8:0] tot_pick [6], use_pick [6];
    bit prev_cfg;

    zero_w    = '{coefficient: '0, last: 1'b0, decode_error: 1'b0};
    zero_last = '{coefficient: '0, last: 1'b1, decode_error: 1'b0};
    err_w     = '{coefficient: '0, last: 1'b1, decode_error: 1'b1};

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // leading slots written first; entries_in_use never reaches past them
    for (int unsigned s = 0; s < LOADED_N; s++) begin
      if (s < 17)
        send_checked(load_word(s, code_of[s], len_of[s], val_init[s]));
      else
        send_checked(load_word(s, 24'($urandom),
                               $urandom_range(0, 1) ? 5'd0 : 5'($urandom_range(25, 31)),
                               16'($urandom)));
    end

    // ---- directed table ----
    add_cfg(hpd_pkg::CFG_ESCAPE_BITS, 9'd0);
    add_cfg(hpd_pkg::CFG_PAIR_TOTAL, 9'd1);
    add_cfg(hpd_pkg::CFG_ENTRIES_IN_USE, 9'd17);
    add_word(cmd_word(hpd_pkg::CMD_START, 8'h00, 3'd0), 0);
    add_word(cmd_word(hpd_pkg::CMD_BYTE, 8'h00, 3'd0), 2, zero_w, zero_last);  // zero pair
    add_word(cmd_word(hpd_pkg::CMD_BYTE, 8'hFF, 3'd7), 0);          // halted: dropped
    add_word(cmd_word(CMD_NOP, 8'hFF, 3'd7), 0);
    add_cfg(hpd_pkg::CFG_PAIR_TOTAL, 9'd0);
    add_word(cmd_word(hpd_pkg::CMD_START, 8'h00, 3'd5), 0);         // empty block
    add_word(cmd_word(hpd_pkg::CMD_BYTE, 8'h00, 3'd0), 0);
    add_cfg(hpd_pkg::CFG_ENTRIES_IN_USE, 9'd0);                     // nothing can match
    add_cfg(hpd_pkg::CFG_PAIR_TOTAL, 9'd3);
    add_word(cmd_word(hpd_pkg::CMD_START, 8'h00, 3'd7), 0);
    add_word(cmd_word(hpd_pkg::CMD_BYTE, 8'hAA, 3'd0), 0);
    add_word(cmd_word(hpd_pkg::CMD_BYTE, 8'h55, 3'd0), 0);
    add_word(cmd_word(hpd_pkg::CMD_BYTE, 8'h33, 3'd0), 0);
    add_word(cmd_word(hpd_pkg::CMD_BYTE, 8'h0F, 3'd0), 1, err_w);   // 25 bits, no code
    add_cfg(hpd_pkg::CFG_ESCAPE_BITS, 9'd15);                       // clamps to 13
    add_cfg(hpd_pkg::CFG_PAIR_TOTAL, 9'd288);
    add_cfg(hpd_pkg::CFG_ENTRIES_IN_USE, 9'd20);
    add_word(cmd_word(hpd_pkg::CMD_START, 8'h00, 3'd3), -1);
    add_word(cmd_word(hpd_pkg::CMD_BYTE, 8'h80, 3'd0), -1);
    add_word(cmd_word(hpd_pkg::CMD_BYTE, 8'hFF, 3'd0), -1);
    add_word(cmd_word(hpd_pkg::CMD_BYTE, 8'hA7, 3'd0), -1);
    add_word(cmd_word(hpd_pkg::CMD_BYTE, 8'h5C, 3'd0), -1);
    add_word(cmd_word(hpd_pkg::CMD_BYTE, 8'hD2, 3'd0), -1);
    add_word(cmd_word(hpd_pkg::CMD_BYTE, 8'h00, 3'd0), -1);
    add_cfg(hpd_pkg::CFG_ESCAPE_BITS, 9'd13);
    add_cfg(hpd_pkg::CFG_PAIR_TOTAL, 9'd511);
    add_cfg(hpd_pkg::CFG_ENTRIES_IN_USE, 9'd20);
    add_word(cmd_word(hpd_pkg::CMD_START, 8'h00, 3'd0), 0);
    add_word(cmd_word(hpd_pkg::CMD_BYTE, 8'hFF, 3'd0), 0);
    add_word(cmd_word(hpd_pkg::CMD_BYTE, 8'hFF, 3'd0), 0);
    add_word(cmd_word(hpd_pkg::CMD_BYTE, 8'hFF, 3'd0), 1, err_w);   // all ones: no code

    prev_cfg = 1'b0;
    foreach (rows[k]) begin
      if (rows[k].kind == ROW_CFG) begin
        if (!prev_cfg) drain();
        write_reg(rows[k].idx, rows[k].data);
        prev_cfg = 1'b1;
      end else begin
        prev_cfg = 1'b0;
        if (rows[k].n_typed < 0) begin
          send_checked(rows[k].w);
        end else begin
          send_word(rows[k].w);
          if (rows[k].n_typed > 0) coef_q.push_back(rows[k].t0);
          if (rows[k].n_typed > 1) coef_q.push_back(rows[k].t1);
        end
      end
    end

    // ---- random blocks over several register settings ----
    esc_pick = '{4'd0, 4'd1, 4'd4, 4'd13, 4'd15, 4'($urandom_range(0, 15))};
    tot_pick = '{9'd1, 9'd2, 9'd5, 9'd288, 9'd511, 9'($urandom_range(3, 40))};
    use_pick = '{9'd17, 9'd20, 9'd17, 9'd20, 9'd20, 9'd17};
    for (int p = 0; p < 6; p++) begin
      drain();
      write_reg(hpd_pkg::CFG_ESCAPE_BITS, {5'd0, esc_pick[p]});
      write_reg(hpd_pkg::CFG_PAIR_TOTAL, tot_pick[p]);
      write_reg(hpd_pkg::CFG_ENTRIES_IN_USE, use_pick[p]);
      for (int unsigned s = 1; s < 17; s++) begin
        if (s != 12 && s != 14 && s != 15)
          send_checked(load_word(s, code_of[s], len_of[s], pick_value()));
      end
      phase_bytes = 0;
      while (phase_bytes < PHASE_BYTES) begin
        send_checked(cmd_word(hpd_pkg::CMD_START, 8'($urandom), 3'($urandom)));
        budget = $urandom_range(1, 14);
        while (!blk_halted && budget > 0 && phase_bytes < PHASE_BYTES) begin
          if ($urandom_range(0, 9) == 0)
            send_checked(cmd_word(CMD_NOP, 8'($urandom), 3'($urandom)));
          send_checked(cmd_word(hpd_pkg::CMD_BYTE, 8'($urandom), 3'($urandom)));
          phase_bytes++;
          budget--;
        end
        if (blk_halted && $urandom_range(0, 2) == 0)   // dropped while halted
          send_checked(cmd_word(hpd_pkg::CMD_BYTE, 8'($urandom), 3'($urandom)));
        if (p == 1) begin
          // sender holds back until the block has caught up
          @(negedge clk);
          in_valid <= 1'b0;
          while (coef_q.size() != 0) @(posedge clk);
        end
      end
    end

    drain();
    if (fails == 0) $display("PASS mp3_huffman_pair_decoder");
    else $display("FAIL mp3_huffman_pair_decoder");
    $finish;
  end

endmodule
